// ===== sv/bhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared constants, codes and controller/datapath interface types for the
// binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bhq_pkg;

  localparam int HEAP_CAPACITY = 256;

  localparam int KEY_W       = 16;
  localparam int TAG_W       = 16;
  localparam int ENTRY_W     = KEY_W + TAG_W;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 9;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    RD_PARENT,
    RD_CHILDREN,
    RD_ENDS
  } rd_sel_e;

  typedef struct packed {
    logic    take;
    logic    rej_full;
    logic    rej_empty;
    logic    push_init;
    logic    pop_init;
    logic    pop_load;
    logic    up_move;
    logic    dn_move;
    logic    wr_ent;
    logic    load_out;
    rd_sel_e rd_sel;
  } bhq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic no_left;
    logic le_parent;
    logic dn_move;
  } bhq_sts_t;

endpackage

// ===== sv/binary_min_heap_queue_core.sv =====
// Flow: a rejected push/pop goes straight to the finish state; a push climbs
//   from the new leaf level by level while it is <= its parent; a pop reads
//   root and last entry, then descends unless that pop empties the heap.
// Each level costs a RAM read state and a compare/write state; a new beat is
//   taken once the result register is loaded, so a waiting result overlaps the next.
// Reset (async, active low) empties the heap; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Binary min-heap priority queue: push key/tag, pop minimum, one result
// beat per input beat with status and entry count.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core import bhq_pkg::*; #(
  parameter int CAPACITY = HEAP_CAPACITY
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   operation_i,
  input  logic [KEY_W-1:0]       push_key_i,
  input  logic [TAG_W-1:0]       push_tag_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [KEY_W-1:0]       popped_key_o,
  output logic [TAG_W-1:0]       popped_tag_o,
  output logic [COUNT_OUT_W-1:0] entry_count_o
);

  bhq_cmd_t cmd;
  bhq_sts_t sts;

  bhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bhq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .push_key_i    (push_key_i),
    .push_tag_i    (push_tag_i),
    .status_o      (status_o),
    .popped_key_o  (popped_key_o),
    .popped_tag_o  (popped_tag_o),
    .entry_count_o (entry_count_o)
  );

endmodule

// ===== sv/bhq_ram.sv =====
// ----------------------------------------------------------------------------
// bhq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== sv/bhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhq_ctrl
// Controller: accepts beats, sequences sift-up / sift-down over the heap
// levels and hands finished results to the output register.
// ----------------------------------------------------------------------------
module bhq_ctrl import bhq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     operation_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  bhq_sts_t sts_i,
  output bhq_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_POP_LD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (operation_i == OP_PUSH) begin
            if (sts_i.full) begin
              cmd_o.rej_full = 1'b1;
              state_d        = S_FIN;
            end else begin
              cmd_o.push_init = 1'b1;
              state_d         = S_PUSH_RD;
            end
          end else begin
            if (sts_i.empty) begin
              cmd_o.rej_empty = 1'b1;
              state_d         = S_FIN;
            end else begin
              cmd_o.pop_init = 1'b1;
              cmd_o.rd_sel   = RD_ENDS;
              state_d        = S_POP_LD;
            end
          end
        end
      end
      S_PUSH_RD: begin
        if (sts_i.at_root) begin
          cmd_o.wr_ent = 1'b1;
          state_d      = S_FIN;
        end else begin
          cmd_o.rd_sel = RD_PARENT;
          state_d      = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        if (sts_i.le_parent) begin
          cmd_o.up_move = 1'b1;
          state_d       = S_PUSH_RD;
        end else begin
          cmd_o.wr_ent = 1'b1;
          state_d      = S_FIN;
        end
      end
      S_POP_LD: begin
        cmd_o.pop_load = 1'b1;
        state_d        = sts_i.empty ? S_FIN : S_DN_RD;
      end
      S_DN_RD: begin
        if (sts_i.no_left) begin
          cmd_o.wr_ent = 1'b1;
          state_d      = S_FIN;
        end else begin
          cmd_o.rd_sel = RD_CHILDREN;
          state_d      = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts_i.dn_move) begin
          cmd_o.dn_move = 1'b1;
          state_d       = S_DN_RD;
        end else begin
          cmd_o.wr_ent = 1'b1;
          state_d      = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/bhq_dpath.sv =====
// ----------------------------------------------------------------------------
// bhq_dpath
// Datapath: heap RAM, fill count, sift cursor, carried entry, child
// compare-select and the result register.
// ----------------------------------------------------------------------------
module bhq_dpath import bhq_pkg::*; #(
  parameter int CAPACITY = HEAP_CAPACITY
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bhq_cmd_t               cmd_i,
  output bhq_sts_t               sts_o,
  input  logic [KEY_W-1:0]       push_key_i,
  input  logic [TAG_W-1:0]       push_tag_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [KEY_W-1:0]       popped_key_o,
  output logic [TAG_W-1:0]       popped_tag_o,
  output logic [COUNT_OUT_W-1:0] entry_count_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = IW + 2;

  logic [CW-1:0]          count_q;
  logic [IW-1:0]          cur_q;
  logic [KEY_W-1:0]       ent_key_q;
  logic [TAG_W-1:0]       ent_tag_q;
  logic [STATUS_W-1:0]    wst_q;
  logic [KEY_W-1:0]       wkey_q;
  logic [TAG_W-1:0]       wtag_q;
  logic [STATUS_W-1:0]    res_st_q;
  logic [KEY_W-1:0]       res_key_q;
  logic [TAG_W-1:0]       res_tag_q;
  logic [CW-1:0]          res_cnt_q;

  logic [ENTRY_W-1:0]     rd_a, rd_b, wdata, child_data;
  logic [IW-1:0]          raddr_a, raddr_b, waddr, parent_idx, child_idx, last_idx;
  logic                   we;
  logic [WW-1:0]          cur_w, left_w, right_w, cnt_w;
  logic [KEY_W-1:0]       left_key, right_key, best_key;
  logic                   take_left, take_right;
  logic [CW+COUNT_OUT_W-1:0] cnt_ext;

  assign cur_w      = WW'(cur_q);
  assign left_w     = (cur_w << 1) + WW'(1);
  assign right_w    = left_w + WW'(1);
  assign cnt_w      = WW'(count_q);
  assign parent_idx = (cur_q - IW'(1)) >> 1;
  assign last_idx   = IW'(count_q - CW'(1));

  assign left_key  = rd_a[ENTRY_W-1:TAG_W];
  assign right_key = rd_b[ENTRY_W-1:TAG_W];

  assign take_left  = ent_key_q > left_key;
  assign best_key   = take_left ? left_key : ent_key_q;
  assign take_right = (right_w < cnt_w) && (best_key > right_key);
  assign child_idx  = take_right ? right_w[IW-1:0] : left_w[IW-1:0];
  assign child_data = take_right ? rd_b : rd_a;

  assign sts_o.full      = (count_q == CW'(CAPACITY));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.at_root   = (cur_q == '0);
  assign sts_o.no_left   = (left_w >= cnt_w);
  assign sts_o.le_parent = (ent_key_q <= left_key);
  assign sts_o.dn_move   = take_left || take_right;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PARENT: begin
        raddr_a = parent_idx;
        raddr_b = right_w[IW-1:0];
      end
      RD_ENDS: begin
        raddr_a = '0;
        raddr_b = last_idx;
      end
      default: begin
        raddr_a = left_w[IW-1:0];
        raddr_b = right_w[IW-1:0];
      end
    endcase
  end

  assign we    = cmd_i.wr_ent || cmd_i.up_move || cmd_i.dn_move;
  assign waddr = cur_q;
  assign wdata = cmd_i.up_move ? rd_a :
                 cmd_i.dn_move ? child_data : {ent_key_q, ent_tag_q};

  bhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.push_init) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.pop_init) begin
      count_q <= count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      ent_key_q <= push_key_i;
      ent_tag_q <= push_tag_i;
      wst_q     <= ST_DONE;
      wkey_q    <= '0;
      wtag_q    <= '0;
    end
    if (cmd_i.rej_full) begin
      wst_q <= ST_FULL;
    end
    if (cmd_i.rej_empty) begin
      wst_q <= ST_EMPTY;
    end
    if (cmd_i.push_init) begin
      cur_q <= IW'(count_q);
    end
    if (cmd_i.pop_load) begin
      wkey_q    <= rd_a[ENTRY_W-1:TAG_W];
      wtag_q    <= rd_a[TAG_W-1:0];
      ent_key_q <= rd_b[ENTRY_W-1:TAG_W];
      ent_tag_q <= rd_b[TAG_W-1:0];
      cur_q     <= '0;
    end
    if (cmd_i.up_move) begin
      cur_q <= parent_idx;
    end
    if (cmd_i.dn_move) begin
      cur_q <= child_idx;
    end
    if (cmd_i.load_out) begin
      res_st_q  <= wst_q;
      res_key_q <= wkey_q;
      res_tag_q <= wtag_q;
      res_cnt_q <= count_q;
    end
  end

  assign cnt_ext       = (CW + COUNT_OUT_W)'(res_cnt_q);
  assign status_o      = res_st_q;
  assign popped_key_o  = res_key_q;
  assign popped_tag_o  = res_tag_q;
  assign entry_count_o = cnt_ext[COUNT_OUT_W-1:0];

endmodule

// ===== sv/bhq_checker.sv =====
// ----------------------------------------------------------------------------
// bhq_checker
// Port-level checks for the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module bhq_checker import bhq_pkg::*; #(
  parameter int CAPACITY = HEAP_CAPACITY
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [STATUS_W-1:0]    status_o,
  input logic [KEY_W-1:0]       popped_key_o,
  input logic [TAG_W-1:0]       popped_tag_o,
  input logic [COUNT_OUT_W-1:0] entry_count_o
);

  localparam int CW = $clog2(CAPACITY + 1) + COUNT_OUT_W;
  localparam logic [CW-1:0] CAP_EXT = CW'(CAPACITY);
  localparam logic [COUNT_OUT_W-1:0] CAP_CNT = CAP_EXT[COUNT_OUT_W-1:0];

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // one beat at a time: input stalls right after an accept
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |->
      entry_count_o == '0 && popped_key_o == '0 && popped_tag_o == '0)
    else $error("bad empty-pop result");

  a_full_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |->
      entry_count_o == CAP_CNT && popped_key_o == '0 && popped_tag_o == '0)
    else $error("bad full-push result");

endmodule

bind binary_min_heap_queue_core bhq_checker #(.CAPACITY(CAPACITY)) u_bhq_checker (.*);

// ===== sim/binary_min_heap_queue_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core_tb
// Self-checking bench for the min-heap priority queue: a short directed
// table, then random push/pop traffic that fills the heap past full and
// drains part of it again, scored against an array-heap predictor.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core_tb;
  import bhq_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } heap_entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [KEY_W-1:0]       key;
    logic [TAG_W-1:0]       tag;
    logic [COUNT_OUT_W-1:0] count;
  } heap_result_t;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             pinned;
    heap_result_t     res;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   operation_i;
  logic [KEY_W-1:0]       push_key_i;
  logic [TAG_W-1:0]       push_tag_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [STATUS_W-1:0]    status_o;
  logic [KEY_W-1:0]       popped_key_o;
  logic [TAG_W-1:0]       popped_tag_o;
  logic [COUNT_OUT_W-1:0] entry_count_o;

  logic         row_pinned;
  heap_result_t row_expect;

  heap_entry_t  heap_mem [HEAP_CAPACITY];
  int unsigned  heap_level;
  heap_result_t expected_results [$];
  stim_row_t    directed_rows [$];

  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned results_taken;
  int unsigned beats_offered;
  int unsigned fill_level;
  int unsigned full_rejects;

  binary_min_heap_queue_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .push_key_i    (push_key_i),
    .push_tag_i    (push_tag_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .popped_key_o  (popped_key_o),
    .popped_tag_o  (popped_tag_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void swap_entries(int unsigned a, int unsigned b);
    heap_entry_t t;
    t = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  function automatic heap_result_t apply_heap_op(logic op, logic [KEY_W-1:0] k,
                                                 logic [TAG_W-1:0] t);
    heap_result_t r;
    int unsigned  cur;
    int unsigned  par;
    int unsigned  lft;
    int unsigned  best;
    r = '0;
    r.status = ST_DONE;
    if (op == OP_PUSH) begin
      if (heap_level >= HEAP_CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        cur = heap_level;
        heap_mem[cur] = '{key: k, tag: t};
        while (cur > 0) begin
          par = (cur - 1) / 2;
          if (heap_mem[cur].key > heap_mem[par].key) break;
          swap_entries(cur, par);
          cur = par;
        end
        heap_level++;
      end
    end else begin
      if (heap_level == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key = heap_mem[0].key;
        r.tag = heap_mem[0].tag;
        heap_level--;
        heap_mem[0] = heap_mem[heap_level];
        cur = 0;
        forever begin
          lft  = 2 * cur + 1;
          best = cur;
          if (lft >= heap_level) break;
          if (heap_mem[best].key > heap_mem[lft].key) best = lft;
          if (lft + 1 < heap_level && heap_mem[best].key > heap_mem[lft + 1].key)
            best = lft + 1;
          if (best == cur) break;
          swap_entries(cur, best);
          cur = best;
        end
      end
    end
    r.count = heap_level[COUNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input heap_result_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch @%0d %s: exp %0d/%h/%h/%0d got %0d/%h/%h/%0d",
               cycle_count, what, want.status, want.key, want.tag, want.count,
               status_o, popped_key_o, popped_tag_o, entry_count_o);
  endtask

  // scoreboard: predict on input beat, compare on output beat
  always @(posedge clk_i) begin
    heap_result_t predicted;
    heap_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted = apply_heap_op(operation_i, push_key_i, push_tag_i);
        expected_results.push_back(row_pinned ? row_expect : predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        results_taken <= results_taken + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", '0);
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status || popped_key_o !== want.key ||
              popped_tag_o !== want.tag || entry_count_o !== want.count)
            report_mismatch("field", want);
        end
      end
    end
  end

  // receiver: random stall runs, one long hold-off to back up the input
  initial begin
    int unsigned stall_run;
    int unsigned r;
    bit          held_long;
    out_stall_i = 1'b0;
    stall_run   = 0;
    held_long   = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_run > 0) begin
        stall_run--;
      end else if (!held_long && results_taken >= 30) begin
        held_long = 1'b1;
        stall_run = LONG_HOLD;
      end else if (((cycle_count / 500) % 4) != 2) begin
        r = $urandom_range(0, 99);
        if (r < 20)      stall_run = $urandom_range(1, 3);
        else if (r < 24) stall_run = $urandom_range(8, 30);
      end
      out_stall_i <= (stall_run > 0);
    end
  end

  function automatic stim_row_t mk_row(logic op, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
                                       logic pinned, logic [STATUS_W-1:0] st,
                                       logic [KEY_W-1:0] pk, logic [TAG_W-1:0] pt,
                                       logic [COUNT_OUT_W-1:0] cnt);
    stim_row_t r;
    r.op         = op;
    r.key        = k;
    r.tag        = t;
    r.pinned     = pinned;
    r.res.status = st;
    r.res.key    = pk;
    r.res.tag    = pt;
    r.res.count  = cnt;
    return r;
  endfunction

  function automatic stim_row_t random_row(int unsigned pop_pct);
    stim_row_t r;
    r = '0;
    r.op = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_PUSH;
    case ($urandom_range(0, 3))
      0:       r.key = KEY_W'($urandom_range(0, 7));
      1:       r.key = 16'hFFFF - KEY_W'($urandom_range(0, 3));
      default: r.key = KEY_W'($urandom);
    endcase
    r.tag = TAG_W'($urandom);
    return r;
  endfunction

  task automatic offer_beat(input stim_row_t r);
    int unsigned gap;
    int unsigned pick;
    in_valid_i  <= 1'b1;
    operation_i <= r.op;
    push_key_i  <= r.key;
    push_tag_i  <= r.tag;
    row_pinned  <= r.pinned;
    row_expect  <= r.res;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_offered++;
    if (r.op == OP_PUSH) begin
      if (fill_level < HEAP_CAPACITY) fill_level++;
      else full_rejects++;
    end else begin
      if (fill_level > 0) fill_level--;
    end
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (((beats_offered / 50) % 4) != 1) begin
      if (pick >= 92)      gap = $urandom_range(8, 40);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    in_valid_i    = 1'b0;
    operation_i   = OP_PUSH;
    push_key_i    = '0;
    push_tag_i    = '0;
    row_pinned    = 1'b0;
    row_expect    = '0;
    cycle_count   = 0;
    mismatches    = 0;
    results_taken = 0;
    beats_offered = 0;
    fill_level    = 0;
    full_rejects  = 0;
    heap_level    = 0;

    directed_rows = '{
      mk_row(OP_POP,  16'h0000, 16'h0000, 1'b1, ST_EMPTY, 16'h0000, 16'h0000, 9'd0),
      mk_row(OP_PUSH, 16'hFFFF, 16'hFFFF, 1'b1, ST_DONE,  16'h0000, 16'h0000, 9'd1),
      mk_row(OP_PUSH, 16'h0000, 16'h0000, 1'b1, ST_DONE,  16'h0000, 16'h0000, 9'd2),
      mk_row(OP_PUSH, 16'h0000, 16'hABCD, 1'b1, ST_DONE,  16'h0000, 16'h0000, 9'd3),
      // equal key pushed later comes out first
      mk_row(OP_POP,  16'h0000, 16'h0000, 1'b1, ST_DONE,  16'h0000, 16'hABCD, 9'd2),
      mk_row(OP_POP,  16'h0000, 16'h0000, 1'b1, ST_DONE,  16'h0000, 16'h0000, 9'd1),
      mk_row(OP_POP,  16'h0000, 16'h0000, 1'b1, ST_DONE,  16'hFFFF, 16'hFFFF, 9'd0),
      mk_row(OP_POP,  16'hFFFF, 16'hFFFF, 1'b1, ST_EMPTY, 16'h0000, 16'h0000, 9'd0),
      // sift-down ties: equal children, child equal to moved entry
      mk_row(OP_PUSH, 16'h0001, 16'h0001, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_PUSH, 16'h0005, 16'h0002, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_PUSH, 16'h0005, 16'h0003, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_PUSH, 16'h0005, 16'h0004, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_PUSH, 16'h8000, 16'hAAAA, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_PUSH, 16'h7FFF, 16'h5555, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_POP,  16'h0000, 16'h0000, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_POP,  16'h0000, 16'h0000, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_PUSH, 16'h0005, 16'h0006, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_POP,  16'h0000, 16'h0000, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_POP,  16'h0000, 16'h0000, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_POP,  16'h0000, 16'h0000, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_POP,  16'h0000, 16'h0000, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_POP,  16'h0000, 16'h0000, 1'b0, ST_DONE,  16'h0000, 16'h0000, 9'd0),
      mk_row(OP_POP,  16'h0000, 16'h0000, 1'b1, ST_EMPTY, 16'h0000, 16'h0000, 9'd0)
    };

    wait (rst_ni);
    @(posedge clk_i);

    foreach (directed_rows[i]) offer_beat(directed_rows[i]);

    repeat (30) offer_beat(random_row(45));
    // fill to capacity, then a few pushes into the full heap
    while (fill_level < HEAP_CAPACITY || full_rejects < 8) offer_beat(random_row(5));
    // mostly pops from the deep heap
    repeat (70) offer_beat(random_row(80));

    in_valid_i <= 1'b0;
    while (results_taken != beats_offered) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_results.size() != 0) report_mismatch("missing beat", expected_results[0]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
